>>> hw/rtl/pwle_pkg.sv
// Shared types and constants for the piecewise linear envelope unit.
package pwle_pkg;

  // Breakpoint store depth and the widths that follow from it.
  localparam int unsigned MaxPoints = 64;
  localparam int unsigned AddrW     = $clog2(MaxPoints);
  localparam int unsigned CountW    = $clog2(MaxPoints + 1);
  localparam int unsigned EntryW    = 64;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FINISH = 2'd1,
    OP_EVAL   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_DUP   = 2'd2,
    ST_NOTAB = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_RD,
    S_A_CMP,
    S_A_CHK,
    S_A_DUP,
    S_A_FULL,
    S_SH_RD,
    S_SH_WR,
    S_A_INS,
    S_E_RD0,
    S_E_CK0,
    S_E_RDN,
    S_E_CKN,
    S_E_RD,
    S_E_CMP,
    S_E_MUL,
    S_E_DIVST,
    S_E_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic signed [31:0] x_value;
    logic signed [31:0] y_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] y_result;
    status_e            status;
  } out_item_t;

  // Request to the serial divider.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

>>> hw/rtl/pwle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pwle_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hw/rtl/pwle_div.sv
// Restoring serial divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
module pwle_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pwle_pkg::div_req_t req_i,
  output pwle_pkg::div_rsp_t rsp_o
);

  logic [31:0] rem_q, rem_d;
  logic [31:0] low_q, low_d;
  logic [31:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] shifted;
  logic [32:0] diff;

  // The caller guarantees the quotient fits in 32 bits, so the upper half
  // of the dividend seeds the remainder directly.
  always_comb begin
    rem_d   = rem_q;
    low_d   = low_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, low_q[31]};
    diff    = shifted - {1'b0, den_q};
    if (req_i.start) begin
      rem_d  = req_i.num[63:32];
      low_d  = req_i.num[31:0];
      den_d  = req_i.den;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d = diff[31:0];
        low_d = {low_q[30:0], 1'b1};
      end else begin
        rem_d = shifted[31:0];
        low_d = {low_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = low_q;

  // Done is registered from the last step of a busy run and rises as busy falls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |-> $past(busy_q) && !busy_q)
    else $error("divider done without a finished run");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 6'd0)
    else $error("divider busy with an exhausted counter");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q && cnt_q == 6'd32)
    else $error("divider did not start");

endmodule

>>> hw/rtl/piecewise_linear_envelope_unit.sv
// Top level of the piecewise linear envelope unit: sequencer, breakpoint banks and divider.
// Every item gives one result. An add runs a binary search and the store checks, then,
// unless it finds a duplicate or a full store, shifts each stored point above the
// insertion place, each shift being one read and one write of the bank RAM; an evaluate
// reads the table ends and, for a query inside the table, runs a bracketing search, then
// the multiply and the 32-step serial divider. The two banks swap roles on finish,
// so no copy is needed. The unit
// takes no new item while one is at work, but a finished result may wait in the output
// register while the next item is accepted.
module piecewise_linear_envelope_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pwle_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pwle_pkg::out_item_t out_item_o
);

  localparam int unsigned AW = pwle_pkg::AddrW;
  localparam int unsigned CW = pwle_pkg::CountW;

  pwle_pkg::state_e state_q, state_d;
  logic [CW-1:0] pcount_q, pcount_d;
  logic [CW-1:0] tcount_q, tcount_d;
  logic          ready_q, ready_d;
  logic          act_q, act_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, ptr_q, ptr_d;
  logic signed [31:0] x_q, x_d, y_q, y_d;
  logic signed [31:0] x1_q, x1_d, y1_q, y1_d, x2_q, x2_d, y2_q, y2_d;
  logic [63:0]   prod_q, prod_d;
  logic [31:0]   dx_q, dx_d;
  logic          neg_q, neg_d;
  logic signed [31:0] res_q, res_d;
  pwle_pkg::status_e  st_q, st_d;
  logic          out_valid_q, out_valid_d;
  pwle_pkg::out_item_t out_q, out_d;

  logic [AW-1:0] raddr, waddr;
  logic [pwle_pkg::EntryW-1:0] wdata, rd0, rd1, rdata;
  logic          we;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic signed [31:0] rx, ry;
  logic signed [32:0] dy, r33;
  logic [32:0]   mag33, dx33, t33;
  logic          use_active;
  pwle_pkg::div_req_t div_req;
  pwle_pkg::div_rsp_t div_rsp;

  // Bank RAMs; the active bank is act_q, the pending bank the other one.
  pwle_ram #(.Width(pwle_pkg::EntryW), .Depth(pwle_pkg::MaxPoints)) u_bank0 (
    .clk_i, .we_i(we && act_q), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rd0));
  pwle_ram #(.Width(pwle_pkg::EntryW), .Depth(pwle_pkg::MaxPoints)) u_bank1 (
    .clk_i, .we_i(we && !act_q), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rd1));

  pwle_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // Read data selection and the shared interpolation arithmetic.
  assign use_active = (state_q == pwle_pkg::S_E_CK0) || (state_q == pwle_pkg::S_E_CKN) ||
                      (state_q == pwle_pkg::S_E_CMP);
  assign rdata   = (use_active == act_q) ? rd1 : rd0;
  assign rx      = signed'(rdata[63:32]);
  assign ry      = signed'(rdata[31:0]);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CW:1];
  assign dy      = {y2_q[31], y2_q} - {y1_q[31], y1_q};
  assign mag33   = dy[32] ? 33'(-dy) : 33'(dy);
  assign dx33    = 33'({x2_q[31], x2_q} - {x1_q[31], x1_q});
  assign t33     = 33'({x_q[31], x_q} - {x1_q[31], x1_q});
  assign r33     = neg_q ? ({y1_q[31], y1_q} - {1'b0, div_rsp.quo})
                         : ({y1_q[31], y1_q} + {1'b0, div_rsp.quo});
  assign in_stall_o  = (state_q != pwle_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Sequencer: next state, datapath updates and memory control.
  always_comb begin
    state_d = state_q;  pcount_d = pcount_q;  tcount_d = tcount_q;
    ready_d = ready_q;  act_d = act_q;  lo_d = lo_q;  hi_d = hi_q;  ptr_d = ptr_q;
    x_d = x_q;  y_d = y_q;  x1_d = x1_q;  y1_d = y1_q;  x2_d = x2_q;  y2_d = y2_q;
    prod_d = prod_q;  dx_d = dx_q;  neg_d = neg_q;  res_d = res_q;  st_d = st_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d = out_q;
    raddr = '0;  waddr = '0;  wdata = {x_q, y_q};  we = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = prod_q + {33'd0, dx_q[31:1]};
    div_req.den   = dx_q;
    unique case (state_q)
      pwle_pkg::S_IDLE: begin
        if (in_valid_i) begin
          x_d = in_item_i.x_value;  y_d = in_item_i.y_value;
          res_d = '0;  st_d = pwle_pkg::ST_OK;  state_d = pwle_pkg::S_DONE;
          unique case (in_item_i.operation)
            pwle_pkg::OP_ADD: begin
              lo_d = '0;  hi_d = pcount_q;  state_d = pwle_pkg::S_A_RD;
            end
            pwle_pkg::OP_FINISH: begin
              act_d = !act_q;  tcount_d = pcount_q;  pcount_d = '0;  ready_d = 1'b1;
            end
            pwle_pkg::OP_EVAL: begin
              if (!ready_q || tcount_q == '0) st_d = pwle_pkg::ST_NOTAB;
              else state_d = pwle_pkg::S_E_RD0;
            end
            pwle_pkg::OP_CLEAR: begin
              pcount_d = '0;  tcount_d = '0;  ready_d = 1'b0;
            end
          endcase
        end
      end
      // Lower-bound search in the pending bank.
      pwle_pkg::S_A_RD: begin
        raddr = mid[AW-1:0];
        state_d = (lo_q < hi_q) ? pwle_pkg::S_A_CMP : pwle_pkg::S_A_CHK;
      end
      pwle_pkg::S_A_CMP: begin
        if (rx < x_q) lo_d = mid + CW'(1);
        else hi_d = mid;
        state_d = pwle_pkg::S_A_RD;
      end
      pwle_pkg::S_A_CHK: begin
        raddr = lo_q[AW-1:0];
        state_d = (lo_q < pcount_q) ? pwle_pkg::S_A_DUP : pwle_pkg::S_A_FULL;
      end
      pwle_pkg::S_A_DUP: begin
        if (rx == x_q) begin
          st_d = pwle_pkg::ST_DUP;  state_d = pwle_pkg::S_DONE;
        end else begin
          state_d = pwle_pkg::S_A_FULL;
        end
      end
      pwle_pkg::S_A_FULL: begin
        if (pcount_q >= CW'(pwle_pkg::MaxPoints)) begin
          st_d = pwle_pkg::ST_FULL;  state_d = pwle_pkg::S_DONE;
        end else begin
          ptr_d = pcount_q;  state_d = pwle_pkg::S_SH_RD;
        end
      end
      // Shift the entries above the insertion place up by one.
      pwle_pkg::S_SH_RD: begin
        raddr = AW'(ptr_q - CW'(1));
        state_d = (ptr_q > lo_q) ? pwle_pkg::S_SH_WR : pwle_pkg::S_A_INS;
      end
      pwle_pkg::S_SH_WR: begin
        we = 1'b1;  waddr = ptr_q[AW-1:0];  wdata = rdata;
        ptr_d = ptr_q - CW'(1);  state_d = pwle_pkg::S_SH_RD;
      end
      pwle_pkg::S_A_INS: begin
        we = 1'b1;  waddr = lo_q[AW-1:0];
        pcount_d = pcount_q + CW'(1);  state_d = pwle_pkg::S_DONE;
      end
      // Evaluate: end checks, then bracketing search in the active bank.
      pwle_pkg::S_E_RD0: begin
        raddr = '0;  state_d = pwle_pkg::S_E_CK0;
      end
      pwle_pkg::S_E_CK0: begin
        x1_d = rx;  y1_d = ry;
        if (x_q <= rx) begin
          res_d = ry;  state_d = pwle_pkg::S_DONE;
        end else begin
          state_d = pwle_pkg::S_E_RDN;
        end
      end
      pwle_pkg::S_E_RDN: begin
        raddr = AW'(tcount_q - CW'(1));  state_d = pwle_pkg::S_E_CKN;
      end
      pwle_pkg::S_E_CKN: begin
        x2_d = rx;  y2_d = ry;
        if (x_q >= rx) begin
          res_d = ry;  state_d = pwle_pkg::S_DONE;
        end else begin
          lo_d = '0;  hi_d = tcount_q - CW'(1);  state_d = pwle_pkg::S_E_RD;
        end
      end
      pwle_pkg::S_E_RD: begin
        raddr = mid[AW-1:0];
        state_d = (hi_q - lo_q > CW'(1)) ? pwle_pkg::S_E_CMP : pwle_pkg::S_E_MUL;
      end
      pwle_pkg::S_E_CMP: begin
        if (x_q > rx) begin
          lo_d = mid;  x1_d = rx;  y1_d = ry;
        end else begin
          hi_d = mid;  x2_d = rx;  y2_d = ry;
        end
        state_d = pwle_pkg::S_E_RD;
      end
      // Interpolation: one multiply, then the rounded serial divide.
      pwle_pkg::S_E_MUL: begin
        prod_d = mag33[31:0] * t33[31:0];
        dx_d = dx33[31:0];  neg_d = dy[32];  state_d = pwle_pkg::S_E_DIVST;
      end
      pwle_pkg::S_E_DIVST: begin
        div_req.start = 1'b1;  state_d = pwle_pkg::S_E_DIV;
      end
      pwle_pkg::S_E_DIV: begin
        if (div_rsp.done) begin
          res_d = r33[31:0];  state_d = pwle_pkg::S_DONE;
        end
      end
      pwle_pkg::S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d.y_result = res_q;
          out_d.status = st_q;
          state_d = pwle_pkg::S_IDLE;
        end
      end
      default: state_d = pwle_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pwle_pkg::S_IDLE;
      pcount_q    <= '0;
      tcount_q    <= '0;
      ready_q     <= 1'b0;
      act_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pcount_q    <= pcount_d;
      tcount_q    <= tcount_d;
      ready_q     <= ready_d;
      act_q       <= act_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;  hi_q <= hi_d;  ptr_q <= ptr_d;
    x_q <= x_d;  y_q <= y_d;  x1_q <= x1_d;  y1_q <= y1_d;  x2_q <= x2_d;  y2_q <= y2_d;
    prod_q <= prod_d;  dx_q <= dx_d;  neg_q <= neg_d;  res_q <= res_d;  st_q <= st_d;
    out_q <= out_d;
  end

  // The pending count never exceeds the bank depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcount_q <= CW'(pwle_pkg::MaxPoints))
    else $error("pending count beyond depth");
  // The divider only runs while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> state_q == pwle_pkg::S_E_DIV)
    else $error("divider busy outside the divide step");
  // A result with an error status carries a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != pwle_pkg::ST_OK |-> out_q.y_result == 32'sd0)
    else $error("nonzero value with error status");
  // A search in the active table stays inside the bracketing interval.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pwle_pkg::S_E_CMP |-> lo_q < hi_q && hi_q < tcount_q)
    else $error("search bounds out of order");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the piecewise linear envelope unit.
`timescale 1ns / 100ps

module testbench;
  import pwle_pkg::*;

  localparam int unsigned Depth = MaxPoints;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  piecewise_linear_envelope_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Mirror of the breakpoint stores.
  logic signed [31:0] pend_x [Depth];
  logic signed [31:0] pend_y [Depth];
  int                 pend_n;
  logic signed [31:0] tab_x [Depth];
  logic signed [31:0] tab_y [Depth];
  int                 tab_n;
  bit                 tab_ready;

  out_item_t result_queue [$];
  int        error_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Round-to-nearest interpolation between two bracketing points.
  function automatic logic signed [31:0] interpolate(
    logic signed [31:0] x1, logic signed [31:0] y1,
    logic signed [31:0] x2, logic signed [31:0] y2, logic signed [31:0] xq);
    longint  dy;
    bit      neg;
    logic [63:0] mag, dx, t, q;
    begin
      dx  = 64'(longint'(x2) - longint'(x1));
      t   = 64'(longint'(xq) - longint'(x1));
      dy  = longint'(y2) - longint'(y1);
      neg = dy < 0;
      mag = neg ? 64'(-dy) : 64'(dy);
      q   = (mag * t + dx / 2) / dx;
      return neg ? 32'(longint'(y1) - longint'(q)) : 32'(longint'(y1) + longint'(q));
    end
  endfunction

  // Applies one item to the mirror and returns the result it should give.
  function automatic out_item_t envelope_step(in_item_t it);
    out_item_t r;
    int pos, lo, hi, mid;
    begin
      r.y_result = '0;
      r.status   = ST_OK;
      case (it.operation)
        OP_ADD: begin
          pos = 0;
          while (pos < pend_n && pend_x[pos] < it.x_value) pos++;
          if (pos < pend_n && pend_x[pos] == it.x_value) begin
            r.status = ST_DUP;
          end else if (pend_n >= Depth) begin
            r.status = ST_FULL;
          end else begin
            for (int i = pend_n; i > pos; i--) begin
              pend_x[i] = pend_x[i-1];
              pend_y[i] = pend_y[i-1];
            end
            pend_x[pos] = it.x_value;
            pend_y[pos] = it.y_value;
            pend_n++;
          end
        end
        OP_FINISH: begin
          tab_x = pend_x;
          tab_y = pend_y;
          tab_n = pend_n;
          pend_n = 0;
          tab_ready = 1'b1;
        end
        OP_EVAL: begin
          if (!tab_ready || tab_n == 0) begin
            r.status = ST_NOTAB;
          end else if (it.x_value <= tab_x[0]) begin
            r.y_result = tab_y[0];
          end else if (it.x_value >= tab_x[tab_n-1]) begin
            r.y_result = tab_y[tab_n-1];
          end else begin
            lo = 0;
            hi = tab_n - 1;
            while (hi - lo > 1) begin
              mid = lo + (hi - lo) / 2;
              if (it.x_value > tab_x[mid]) lo = mid;
              else hi = mid;
            end
            r.y_result = interpolate(tab_x[lo], tab_y[lo], tab_x[hi], tab_y[hi],
                                     it.x_value);
          end
        end
        default: begin
          pend_n = 0;
          tab_n = 0;
          tab_ready = 1'b0;
        end
      endcase
      return r;
    end
  endfunction

  // Offers one item, with an optional random gap before it. Valid stays high
  // after an accept so that back-to-back items need no second assignment.
  task automatic send_item(op_e op, logic signed [31:0] xv, logic signed [31:0] yv);
    in_item_t  it;
    out_item_t want;
    begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      it.operation = op;
      it.x_value   = xv;
      it.y_value   = yv;
      in_valid_i <= 1'b1;
      in_item_i  <= it;
      do @(posedge clk_i); while (in_stall_o);
      want = envelope_step(it);
      result_queue = {result_queue, want};
    end
  endtask

  function automatic logic signed [31:0] rand_word();
    return $urandom();
  endfunction

  // Random x spread that mixes narrow and full-range values.
  function automatic logic signed [31:0] rand_x();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $signed(32'($urandom_range(4000))) - 2000;
      default: return $signed(32'($urandom_range(32'h0040_0000))) - 32'sh0020_0000;
    endcase
  endfunction

  // Receiver: random stall, plus a long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Checks each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_queue.size() == 0) begin
        $error("result with no item pending: y_result %0d status %0d",
               out_item_o.y_result, out_item_o.status);
        error_count++;
      end else begin
        want = result_queue.pop_front();
        if (out_item_o.y_result !== want.y_result) begin
          $error("y_result: expected %0d, actual %0d", want.y_result, out_item_o.y_result);
          error_count++;
        end
        if (out_item_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_item_o.status);
          error_count++;
        end
      end
    end
  end

  // Edge values, every operation and each special case but a full store.
  task automatic test_directed();
    begin
      send_item(OP_EVAL, 32'sd0, 32'sd0);
      send_item(OP_FINISH, 32'sd0, 32'sd0);
      send_item(OP_EVAL, 32'sd5, 32'sd0);
      send_item(OP_ADD, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_item(OP_FINISH, 32'sd0, 32'sd0);
      send_item(OP_EVAL, 32'sh8000_0000, 32'sd0);
      send_item(OP_ADD, 32'sh8000_0000, 32'sh8000_0000);
      send_item(OP_ADD, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_item(OP_ADD, 32'sh7fff_ffff, 32'sd1);
      send_item(OP_ADD, 32'sd0, 32'sh5555_5555);
      send_item(OP_FINISH, 32'sd0, 32'sd0);
      send_item(OP_EVAL, 32'sh8000_0001, 32'shffff_ffff);
      send_item(OP_EVAL, 32'sh7fff_fffe, 32'sd0);
      send_item(OP_EVAL, 32'sh8000_0000, 32'sd0);
      send_item(OP_EVAL, 32'sh7fff_ffff, 32'sd0);
      send_item(OP_EVAL, 32'shc000_0000, 32'sd0);
      send_item(OP_EVAL, 32'sh0000_0001, 32'sd0);
      send_item(OP_CLEAR, 32'shffff_ffff, 32'shffff_ffff);
      send_item(OP_EVAL, 32'sd0, 32'sd0);
    end
  endtask

  // Fills the pending store past its depth, then evaluates the full table.
  task automatic test_full_store();
    begin
      for (int i = 0; i < Depth + 4; i++)
        send_item(OP_ADD, rand_x(), rand_word());
      send_item(OP_FINISH, 32'sd0, 32'sd0);
      for (int i = 0; i < 30; i++) send_item(OP_EVAL, rand_x(), rand_word());
    end
  endtask

  // Table builds of random size followed by queries.
  task automatic test_random(int n_items);
    int sent, npts;
    begin
      sent = 0;
      while (sent < n_items) begin
        if ($urandom_range(9) == 0) begin
          send_item(op_e'($urandom_range(3)), rand_x(), rand_word());
          sent++;
        end else begin
          npts = ($urandom_range(7) == 0) ? $urandom_range(70) : $urandom_range(1, 10);
          for (int i = 0; i < npts; i++) send_item(OP_ADD, rand_x(), rand_word());
          send_item(OP_FINISH, rand_word(), rand_word());
          sent += npts + 1;
          for (int i = 0; i < $urandom_range(2, 12); i++) begin
            send_item(OP_EVAL, rand_x(), rand_word());
            sent++;
          end
        end
      end
    end
  endtask

  // Long receiver hold-off while items keep coming.
  task automatic test_backpressure();
    begin
      hold_cycles <= 400;
      for (int i = 0; i < 8; i++) send_item(OP_ADD, rand_x(), rand_word());
      send_item(OP_FINISH, 32'sd0, 32'sd0);
      for (int i = 0; i < 10; i++) send_item(OP_EVAL, rand_x(), 32'sd0);
    end
  endtask

  task automatic drain();
    begin
      in_valid_i <= 1'b0;
      while (result_queue.size() != 0) @(posedge clk_i);
      repeat (60) @(posedge clk_i);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    error_count   = 0;
    hold_cycles   = 0;
    send_idle_pct = 7;
    recv_idle_pct = 66;
    pend_n = 0;
    tab_n = 0;
    tab_ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_full_store();
    test_backpressure();
    test_random(330);
    send_idle_pct = 66;
    recv_idle_pct = 7;
    test_random(330);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(330);
    drain();

    if (error_count == 0) begin
      $display("piecewise_linear_envelope_unit regression: pass");
    end else begin
      $display("piecewise_linear_envelope_unit regression: fail");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #20ms;
    $display("piecewise_linear_envelope_unit regression: fail");
    $finish;
  end

endmodule
